@@ src/smf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TDATA_W  = 16;

  // command broadcast from the controller to every cell of the window
  typedef struct packed {
    logic                push;  // shift one sample into the window
    logic                load;  // line start: fill the window with x
    logic [SAMPLE_W-1:0] x;     // sample being pushed
  } smf_cmd_t;

endpackage

@@ src/sliding_median_filter.sv @@
`timescale 1ns / 1ps
// A result is registered: it appears on out_tvalid in the cycle after the push that causes it.
// Throughput: one sample per cycle while the output is not stalled; after a sample with
//   tlast the input stays blocked while the line tail is flushed.
// The sorted cell row takes each push in a single register update; a stalled output holds the push.
// Reset (rst_n low, synchronous) clears the line count, flush state and output valid.
// ----------------------------------------------------------------------------
// sliding_median_filter
// Upper-median filter over a line of samples with edge padding, built on a
// sorted row of cells with age tags.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
  parameter int HALF_WINDOW = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [smf_pkg::TDATA_W-1:0] in_tdata,   // [11:0] sample
  input  logic                        in_tlast,   // end_of_line
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [smf_pkg::TDATA_W-1:0] out_tdata,  // [11:0] median
  output logic                        out_tlast   // last_out
);
  import smf_pkg::*;

  localparam int   CNT_W  = $clog2(HALF_WINDOW + 1);
  localparam logic ONE_HW = (HALF_WINDOW == 1);

  logic [CNT_W-1:0]    count_r,    count_nxt;
  logic [CNT_W-1:0]    left_r,     left_nxt;
  logic                flushing_r, flushing_nxt;
  logic [SAMPLE_W-1:0] hold_r,     hold_nxt;
  logic                ovalid_r,   ovalid_nxt;
  logic [SAMPLE_W-1:0] omed_r,     omed_nxt;
  logic                olast_r,    olast_nxt;

  logic                slot_free;
  logic                acc;
  logic                fpush;
  logic                emit;
  logic                last;
  logic [SAMPLE_W-1:0] median_nxt;
  smf_cmd_t            cmd;

  assign slot_free = !ovalid_r || out_tready;
  assign in_tready = !flushing_r && slot_free;
  assign acc       = in_tvalid && in_tready;
  assign fpush     = flushing_r && slot_free;

  always_comb begin
    cmd.push = acc || fpush;
    cmd.x    = flushing_r ? hold_r : in_tdata[SAMPLE_W-1:0];
    cmd.load = acc && (count_r == '0);
    emit     = cmd.push && (count_r >= CNT_W'(HALF_WINDOW - 1));
    last     = (acc && in_tlast && ONE_HW) || (fpush && (left_r == CNT_W'(1)));

    count_nxt    = count_r;
    left_nxt     = left_r;
    flushing_nxt = flushing_r;
    hold_nxt     = hold_r;
    if (last) begin
      count_nxt = '0;
    end else if (cmd.push && (count_r < CNT_W'(HALF_WINDOW))) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (acc && in_tlast && !ONE_HW) begin
      // tail padding: repeat the last sample HALF_WINDOW-1 more times
      flushing_nxt = 1'b1;
      left_nxt     = CNT_W'(HALF_WINDOW - 1);
      hold_nxt     = cmd.x;
    end else if (fpush) begin
      left_nxt = left_r - CNT_W'(1);
      if (left_r == CNT_W'(1)) begin
        flushing_nxt = 1'b0;
      end
    end

    ovalid_nxt = ovalid_r;
    omed_nxt   = omed_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      omed_nxt   = median_nxt;
      olast_nxt  = last;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      flushing_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      flushing_r <= flushing_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    hold_r  <= hold_nxt;
    omed_r  <= omed_nxt;
    olast_r <= olast_nxt;
  end

  smf_chain #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .median_nxt (median_nxt)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(TDATA_W - SAMPLE_W){1'b0}}, omed_r};
  assign out_tlast  = olast_r;

endmodule

@@ src/smf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window: holds a sample and its age, and on a push
// takes its new contents from itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int WIN_LEN = 20,
  parameter int IDX     = 0
) (
  input  logic                                 clk,
  input  smf_pkg::smf_cmd_t                    cmd,
  input  logic [smf_pkg::SAMPLE_W-1:0]         left_val,
  input  logic                                 left_le,
  input  logic [$clog2(WIN_LEN)-1:0]           left_age,
  input  logic [smf_pkg::SAMPLE_W-1:0]         right_val,
  input  logic                                 right_le,
  input  logic [$clog2(WIN_LEN)-1:0]           right_age,
  input  logic                                 del_in,
  output logic                                 del_out,
  output logic [smf_pkg::SAMPLE_W-1:0]         val,
  output logic                                 le,
  output logic [$clog2(WIN_LEN)-1:0]           age,
  output logic [smf_pkg::SAMPLE_W-1:0]         val_nxt
);
  import smf_pkg::*;

  localparam int AGE_W = $clog2(WIN_LEN);

  logic [SAMPLE_W-1:0] value_r;
  logic [AGE_W-1:0]    age_r;
  logic [AGE_W-1:0]    age_nxt;
  logic [SAMPLE_W-1:0] cur_val;
  logic                cur_le;
  logic [AGE_W-1:0]    cur_age;
  logic [SAMPLE_W-1:0] prev_val;
  logic                prev_le;
  logic [AGE_W-1:0]    prev_age;
  logic                del_here;

  assign val = value_r;
  assign age = age_r;

  always_comb begin
    le       = (value_r <= cmd.x);
    del_here = (age_r == AGE_W'(WIN_LEN - 1));
    del_out  = del_in || del_here;
    // at or right of the oldest entry the window closes up from the right
    cur_val  = del_out ? right_val : value_r;
    cur_le   = del_out ? right_le  : le;
    cur_age  = del_out ? right_age : age_r;
    prev_val = del_in  ? value_r   : left_val;
    prev_le  = del_in  ? le        : left_le;
    prev_age = del_in  ? age_r     : left_age;
    val_nxt  = value_r;
    age_nxt  = age_r;
    if (cmd.load) begin
      val_nxt = cmd.x;
      age_nxt = AGE_W'(IDX);
    end else if (cmd.push) begin
      if (cur_le) begin
        val_nxt = cur_val;
        age_nxt = cur_age + AGE_W'(1);
      end else if (prev_le) begin
        val_nxt = cmd.x;
        age_nxt = '0;
      end else begin
        val_nxt = prev_val;
        age_nxt = prev_age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= val_nxt;
    age_r   <= age_nxt;
  end

endmodule

@@ src/smf_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_chain
// Row of cells that keeps the window sorted; the rank HALF_WINDOW cell
// gives the upper median of the window after the current push.
// ----------------------------------------------------------------------------
module smf_chain #(
  parameter int HALF_WINDOW = 10
) (
  input  logic                         clk,
  input  smf_pkg::smf_cmd_t            cmd,
  output logic [smf_pkg::SAMPLE_W-1:0] median_nxt
);
  import smf_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WINDOW;
  localparam int AGE_W   = $clog2(WIN_LEN);

  logic [SAMPLE_W-1:0] val     [WIN_LEN];
  logic                le      [WIN_LEN];
  logic [AGE_W-1:0]    age     [WIN_LEN];
  logic [SAMPLE_W-1:0] val_nxt [WIN_LEN];
  logic                del     [WIN_LEN+1];

  assign del[0]     = 1'b0;
  assign median_nxt = val_nxt[HALF_WINDOW];

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    logic [SAMPLE_W-1:0] l_val;
    logic                l_le;
    logic [AGE_W-1:0]    l_age;
    logic [SAMPLE_W-1:0] r_val;
    logic                r_le;
    logic [AGE_W-1:0]    r_age;

    if (i == 0) begin : g_lb
      // nothing to the left: behaves as minus infinity
      assign l_val = '0;
      assign l_le  = 1'b1;
      assign l_age = '0;
    end else begin : g_ln
      assign l_val = val[i-1];
      assign l_le  = le[i-1];
      assign l_age = age[i-1];
    end

    if (i == WIN_LEN - 1) begin : g_rb
      // nothing to the right: behaves as plus infinity
      assign r_val = '0;
      assign r_le  = 1'b0;
      assign r_age = '0;
    end else begin : g_rn
      assign r_val = val[i+1];
      assign r_le  = le[i+1];
      assign r_age = age[i+1];
    end

    smf_cell #(
      .WIN_LEN (WIN_LEN),
      .IDX     (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_val  (l_val),
      .left_le   (l_le),
      .left_age  (l_age),
      .right_val (r_val),
      .right_le  (r_le),
      .right_age (r_age),
      .del_in    (del[i]),
      .del_out   (del[i+1]),
      .val       (val[i]),
      .le        (le[i]),
      .age       (age[i]),
      .val_nxt   (val_nxt[i])
    );
  end

endmodule

@@ test/smf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_checker
// Watches both stream channels of the median filter. Each accepted input
// request is run through a local model of the padded window, and each
// produced filtered sample is compared against the oldest expected one.
// ----------------------------------------------------------------------------
module smf_checker #(
  parameter int HALF_WINDOW = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [smf_pkg::TDATA_W-1:0] in_tdata,   // [11:0] sample
  input  logic                        in_tlast,   // end_of_line
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [smf_pkg::TDATA_W-1:0] out_tdata,  // [11:0] median
  input  logic                        out_tlast,  // last_out
  output int                          err_count,
  output int                          pending
);

  localparam int WIN_LEN = 2 * HALF_WINDOW;
  localparam int SW      = smf_pkg::SAMPLE_W;

  typedef struct packed {
    logic [SW-1:0] median;
    logic          last;
  } filt_result_t;

  filt_result_t  filt_expected_q[$];
  logic [SW-1:0] line_win [WIN_LEN];
  int            line_fill;

  initial begin
    err_count = 0;
    pending   = 0;
    line_fill = 0;
  end

  // rank HALF_WINDOW of the current window, ascending
  function automatic logic [SW-1:0] window_upper_median();
    logic [SW-1:0] srt [WIN_LEN];
    logic [SW-1:0] t;
    int            j;
    for (int i = 0; i < WIN_LEN; i++) srt[i] = line_win[i];
    for (int i = 1; i < WIN_LEN; i++) begin
      t = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > t) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = t;
    end
    return srt[HALF_WINDOW];
  endfunction

  task automatic predict_filtered(input logic [SW-1:0] s, input logic eol);
    int           pushes;
    filt_result_t r;
    // line start: front padding fills the whole window
    if (line_fill == 0) begin
      for (int i = 0; i < WIN_LEN; i++) line_win[i] = s;
    end
    // end of line pushes the sample plus HALF_WINDOW-1 tail copies
    pushes = eol ? HALF_WINDOW : 1;
    for (int p = 0; p < pushes; p++) begin
      for (int k = 0; k < WIN_LEN - 1; k++) line_win[k] = line_win[k + 1];
      line_win[WIN_LEN - 1] = s;
      if (line_fill < HALF_WINDOW) line_fill++;
      if (line_fill >= HALF_WINDOW) begin
        r.median = window_upper_median();
        r.last   = eol && (p == pushes - 1);
        filt_expected_q = {filt_expected_q, r};
      end
    end
    if (eol) line_fill = 0;
  endtask

  always @(posedge clk) begin
    filt_result_t want;
    if (!rst_n) begin
      line_fill = 0;
      filt_expected_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_filtered(in_tdata[SW-1:0], in_tlast);
      if (out_tvalid && out_tready) begin
        if (filt_expected_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result median=%0d last=%0b",
                     $realtime, out_tdata[SW-1:0], out_tlast);
        end else begin
          want = filt_expected_q.pop_front();
          if (out_tdata[SW-1:0] !== want.median || out_tlast !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch median exp=%0d got=%0d last exp=%0b got=%0b",
                       $realtime, want.median, out_tdata[SW-1:0], want.last, out_tlast);
          end
        end
      end
    end
    pending = filt_expected_q.size();
  end

endmodule

@@ test/tb_sliding_median_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_median_filter
// Drives lines of samples into the median filter with random gaps
// and output back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;

  localparam int HALF_WINDOW = 10;
  localparam int SW          = smf_pkg::SAMPLE_W;
  localparam int MAX_SAMPLE  = (1 << SW) - 1;
  localparam int RAND_ITEMS  = 470;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [smf_pkg::TDATA_W-1:0] in_tdata;   // [11:0] sample
  logic                        in_tlast;   // end_of_line
  logic                        out_tvalid;
  logic                        out_tready;
  logic [smf_pkg::TDATA_W-1:0] out_tdata;  // [11:0] median
  logic                        out_tlast;  // last_out

  int   err_count;
  int   pending;
  int   items_sent;
  logic gaps_on;
  logic stall_en;

  sliding_median_filter #(.HALF_WINDOW(HALF_WINDOW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  smf_checker #(.HALF_WINDOW(HALF_WINDOW)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_sliding_median_filter: done, errors");
    $finish;
  end

  // mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // output back-pressure
  initial begin
    int hold;
    out_tready = 1'b0;
    hold       = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (stall_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        hold = pick_gap();
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_sample(input int s, input logic eol);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(smf_pkg::TDATA_W - SW){1'b0}}, s[SW-1:0]};
    in_tlast  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // style: 0 uniform, 1 clustered with ties, 2 flat with spikes, 3 extremes only
  task automatic send_line(input int len, input int style);
    int base;
    int v;
    base = $urandom_range(0, MAX_SAMPLE);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = $urandom_range(0, MAX_SAMPLE);
        1: begin
          v = base + $urandom_range(0, 6) - 3;
          if (v < 0) v = 0;
          if (v > MAX_SAMPLE) v = MAX_SAMPLE;
        end
        2: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_SAMPLE) : base;
        default: v = $urandom_range(0, 1) ? MAX_SAMPLE : 0;
      endcase
      send_sample(v, i == len - 1);
    end
  endtask

  initial begin
    int r;
    int len;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    items_sent = 0;
    gaps_on    = 1'b1;
    stall_en   = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-sample lines at both extremes
    send_sample(MAX_SAMPLE, 1'b1);
    send_sample(0, 1'b1);
    // short line, never reaches a full window before the end
    send_sample(0, 1'b0);
    send_sample(MAX_SAMPLE, 1'b0);
    send_sample(2048, 1'b1);
    // exactly HALF_WINDOW samples
    for (int i = 0; i < HALF_WINDOW; i++)
      send_sample((i % 2) ? MAX_SAMPLE : 0, i == HALF_WINDOW - 1);
    // a few past full, with ties
    for (int i = 0; i < HALF_WINDOW + 2; i++)
      send_sample((i < 6) ? 1365 : 2730, i == HALF_WINDOW + 1);

    while (items_sent < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10)      len = 1;
      else if (r < 40) len = $urandom_range(2, HALF_WINDOW - 1);
      else if (r < 80) len = $urandom_range(HALF_WINDOW, 25);
      else             len = $urandom_range(26, 50);
      // some lines run back to back with no stalls at all
      r = $urandom_range(0, 3);
      gaps_on  = (r != 0);
      stall_en <= (r != 0);
      send_line(len, $urandom_range(0, 3));
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    stall_en  <= 1'b1;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * HALF_WINDOW + 4) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("tb_sliding_median_filter: done, clean");
    else
      $display("tb_sliding_median_filter: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
src/smf_pkg.sv
src/smf_cell.sv
src/smf_chain.sv
src/sliding_median_filter.sv
test/smf_checker.sv
test/tb_sliding_median_filter.sv
